// File: rtl/fpcr_pkg.sv
// ----------------------------------------------------------------------------
// fpcr_pkg
// Shared widths, constants and the word type carried down the cube root
// pipeline.
// ----------------------------------------------------------------------------
package fpcr_pkg;

    // port widths
    localparam int RAD_W  = 17;
    localparam int ROOT_W = 16;

    // the accepted cube never exceeds the larger of the radicand and 1.0
    localparam int F_W    = RAD_W;
    // the accepted root never exceeds 2.0 in Q14, well inside 17 bits
    localparam int R_W    = 17;
    // a trial cube grows by at most 3.375 over an accepted cube
    localparam int CUBE_W = F_W + 2;
    // a trial root grows by at most 1.5 over an accepted root
    localparam int TR_W   = R_W + 1;

    // 1.0 in Q14
    localparam logic [F_W-1:0] Q14_ONE = F_W'(16384);

    // word passed from one trial stage to the next
    typedef struct packed {
        logic [RAD_W-1:0] radicand;
        logic [F_W-1:0]   cube;
        logic [R_W-1:0]   root;
    } t_trial;

endpackage

// File: rtl/fixed_point_cube_root_unit.sv
// ----------------------------------------------------------------------------
// fixed_point_cube_root_unit
// Pipelined Q14 cube root by shift-and-add multiplicative normalisation.
// ----------------------------------------------------------------------------
// Usage:
//   A radicand word (unsigned Q14, 16384 is 1.0) is taken on i_radicand at
//   each rising edge where start is high and busy is low. busy is held low,
//   so a new word may be given in every cycle.
//   The root (unsigned Q14) appears on o_root with o_valid high for exactly
//   one cycle, after the entry register and the stage registers: one stage
//   for the 8.0 trial and one stage for each shift from 1 to STEPS.
//   Throughput is one word per cycle; each trial stage holds four narrow
//   shift-adds and one compare, which sets the clock period.
//   Results leave in the order their words arrived. The receiver cannot
//   stall, and the pipeline never holds a word back.
//   Radicands below 1.0 give 1.0.
//   Reset (i_rst_n low at a rising edge) clears every valid bit; words in
//   flight are dropped and no strobe follows.
// ----------------------------------------------------------------------------
module fixed_point_cube_root_unit #(
    parameter int STEPS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [fpcr_pkg::RAD_W-1:0]  i_radicand,
    output logic                        o_valid,
    output logic [fpcr_pkg::ROOT_W-1:0] o_root
);
    import fpcr_pkg::*;

    logic             take;
    logic             keep8;
    logic [CUBE_W-1:0] cube8;
    logic [TR_W-1:0]   root2;

    logic     r_vld0;
    t_trial   r_word0;
    logic     n_vld0;
    t_trial   n_word0;

    logic     stage_vld  [0:STEPS];
    t_trial   stage_word [0:STEPS];

    // always ready for a new word
    assign busy = 1'b0;
    assign take = start && !busy;

    // first trial: cube 8.0 against root 2.0
    always_comb begin
        cube8            = CUBE_W'(Q14_ONE) << 3;
        root2            = TR_W'(Q14_ONE) << 1;
        keep8            = cube8 <= CUBE_W'(i_radicand);
        n_vld0           = take;
        n_word0.radicand = i_radicand;
        n_word0.cube     = keep8 ? cube8[F_W-1:0] : Q14_ONE;
        n_word0.root     = keep8 ? root2[R_W-1:0] : R_W'(Q14_ONE);
    end

    // entry stage valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else begin
            r_vld0 <= n_vld0;
        end
    end

    // entry stage payload
    always_ff @(posedge i_clk) begin
        r_word0 <= n_word0;
    end

    assign stage_vld[0]  = r_vld0;
    assign stage_word[0] = r_word0;

    // one stage per shift
    for (genvar g = 1; g <= STEPS; g++) begin : g_trial
        fpcr_stage #(
            .K(g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (stage_vld[g-1]),
            .i_word  (stage_word[g-1]),
            .o_vld   (stage_vld[g]),
            .o_word  (stage_word[g])
        );
    end

    // result straight from the last stage register
    assign o_valid = stage_vld[STEPS];
    assign o_root  = stage_word[STEPS].root[ROOT_W-1:0];

endmodule

// File: rtl/fpcr_stage.sv
// ----------------------------------------------------------------------------
// fpcr_stage
// One trial of the normalisation: grows the cube by (1 + 2^-K)^3 with three
// truncating shift-adds, the root by (1 + 2^-K), and keeps the trial when
// the cube does not exceed the radicand. One register stage.
// ----------------------------------------------------------------------------
module fpcr_stage #(
    parameter int K = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  fpcr_pkg::t_trial i_word,
    output logic           o_vld,
    output fpcr_pkg::t_trial o_word
);
    import fpcr_pkg::*;

    logic [CUBE_W-1:0] cube_base;
    logic [CUBE_W-1:0] cube_a;
    logic [CUBE_W-1:0] cube_b;
    logic [CUBE_W-1:0] cube_c;
    logic [TR_W-1:0]   root_base;
    logic [TR_W-1:0]   root_t;
    logic              keep;

    logic     r_vld;
    t_trial   r_word;
    logic     n_vld;
    t_trial   n_word;

    // trial cube and root
    always_comb begin
        cube_base = CUBE_W'(i_word.cube);
        cube_a    = cube_base + (cube_base >> K);
        cube_b    = cube_a + (cube_a >> K);
        cube_c    = cube_b + (cube_b >> K);
        root_base = TR_W'(i_word.root);
        root_t    = root_base + (root_base >> K);
        keep      = cube_c <= CUBE_W'(i_word.radicand);
    end

    // select kept or previous values
    always_comb begin
        n_vld           = i_vld;
        n_word.radicand = i_word.radicand;
        n_word.cube     = keep ? cube_c[F_W-1:0] : i_word.cube;
        n_word.root     = keep ? root_t[R_W-1:0] : i_word.root;
    end

    // valid bit under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_vld  = r_vld;
    assign o_word = r_word;

endmodule
